[src/pva_pkg.sv]
// Shared types, sizes and codes of the polyphonic voice allocator.
// No dependencies; every other file imports this package.
package pva_pkg;

	localparam int NUM_VOICES = 8;
	localparam int HELD_DEPTH = 16;

	localparam int KEY_W  = 7;
	localparam int VCFG_W = 4;
	localparam int TICK_W = 8;
	localparam int CV_W   = 12;
	localparam int MASK_W = 8;
	localparam int STAT_W = 3;
	localparam int VOUT_W = 3;
	localparam int HOUT_W = 5;
	localparam int CFG_W  = 8;

	localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int HIDX_W = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
	localparam int HCNT_W = $clog2(HELD_DEPTH + 1);

	localparam logic [VCFG_W-1:0] VOICE_COUNT_RST   = VCFG_W'(8);
	localparam logic [TICK_W-1:0] TRIGGER_TICKS_RST = TICK_W'(5);

	localparam logic [KEY_W-1:0] PITCH_BASE = KEY_W'(53);
	localparam logic [15:0]      PITCH_MUL  = 16'd273;
	localparam logic [13:0]      CV_MAX     = 14'd4095;

	localparam logic [1:0] REQ_TICK     = 2'd0;
	localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
	localparam logic [1:0] REQ_NOTE_OFF = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_VOICE = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_HELD = 3'd4;
	localparam logic [STAT_W-1:0] ST_TICK     = 3'd5;

	localparam logic REG_VOICE_COUNT   = 1'b0;
	localparam logic REG_TRIGGER_TICKS = 1'b1;

	typedef enum logic [1:0] {
		VC_HOLD,
		VC_TICK,
		VC_GATE_OFF,
		VC_LOAD
	} vc_op_t;

	typedef enum logic [1:0] {
		HC_HOLD,
		HC_SHIFT,
		HC_WRITE
	} hc_op_t;

	typedef struct packed {
		hc_op_t              op;
		logic [HIDX_W-1:0]   pos;
		logic [KEY_W-1:0]    wkey;
	} hc_cmd_t;

	typedef struct packed {
		logic key_eq;
		logic gated_eq;
		logic gate;
		logic trig;
	} vc_flags_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_VON_CHECK,
		S_STEAL_WALK,
		S_STEAL_OFF,
		S_LOAD,
		S_OFF_WALK,
		S_OFF_DEL,
		S_REV_WALK,
		S_DONE
	} state_t;

endpackage

[src/pva_held_cell.sv]
// One entry of the held-key chain: holds a key, takes its right neighbor on a shift at or below its index.
// Depends on pva_pkg.
module pva_held_cell import pva_pkg::*; (
	input  logic              clk,
	input  logic [HIDX_W-1:0] idx,
	input  hc_cmd_t           cmd,
	input  logic [KEY_W-1:0]  nxt_key,
	output logic [KEY_W-1:0]  key_q
);

	always_ff @(posedge clk) begin
		case (cmd.op)
			HC_SHIFT: begin
				if (idx >= cmd.pos) key_q <= nxt_key;
			end
			HC_WRITE: begin
				if (idx == cmd.pos) key_q <= cmd.wkey;
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

endmodule

[src/pva_voice_cell.sv]
// One voice: key, gate, trigger and trigger countdown, with key compare flags.
// Depends on pva_pkg.
module pva_voice_cell import pva_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  vc_op_t            op,
	input  logic              sel,
	input  logic [KEY_W-1:0]  vkey,
	input  logic [TICK_W-1:0] ticks,
	output vc_flags_t         flags
);

	logic [KEY_W-1:0]  key_q;
	logic              gate_q;
	logic              trig_q;
	logic [TICK_W-1:0] left_q;
	logic [TICK_W-1:0] left_dec;

	assign left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			gate_q <= 1'b0;
			trig_q <= 1'b0;
			left_q <= '0;
		end else begin
			case (op)
				VC_TICK: begin
					if (trig_q) begin
						left_q <= left_dec;
						if (left_dec == '0) trig_q <= 1'b0;
					end
				end
				VC_GATE_OFF: begin
					if (gate_q && key_q == vkey) gate_q <= 1'b0;
				end
				VC_LOAD: begin
					if (sel) begin
						key_q  <= vkey;
						gate_q <= 1'b1;
						trig_q <= 1'b1;
						left_q <= ticks;
					end
				end
				default: begin
					key_q <= key_q;
				end
			endcase
		end
	end

	always_comb begin
		flags.key_eq   = (key_q == vkey);
		flags.gated_eq = gate_q && (key_q == vkey);
		flags.gate     = gate_q;
		flags.trig     = trig_q;
	end

endmodule

[src/poly_voice_allocator.sv]
// Polyphonic voice allocator with oldest-note stealing, one event at a time.
// Each held-list walk rotates the key chain once, one entry a cycle; the steal walk checks
// each key against the active voices, the revoice walk against all voices, note-off its key.
// The next event is taken the cycle after the result is registered, even while it waits.
// Reset clears voices, held count and result valid; voice count 8, trigger ticks 5; key cells keep data.
module poly_voice_allocator import pva_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic              cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic [KEY_W-1:0]  key,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [MASK_W-1:0] gate_mask,
	output logic [MASK_W-1:0] trigger_mask,
	output logic              cv_valid,
	output logic [VOUT_W-1:0] cv_voice,
	output logic [CV_W-1:0]   cv_value,
	output logic [HOUT_W-1:0] held_total
);

	state_t state_q, state_d;

	logic [VCFG_W-1:0] vc_q;
	logic [TICK_W-1:0] tt_q;
	logic [1:0]        req_q;
	logic [KEY_W-1:0]  key_q;
	logic [HCNT_W-1:0] cnt_q;
	logic [HIDX_W-1:0] step_q;
	logic              found_q;
	logic [KEY_W-1:0]  fkey_q;
	logic [VIDX_W-1:0] target_q;
	logic [HIDX_W-1:0] pos_q;
	logic              revoice_q;
	logic [STAT_W-1:0] status_q;
	logic              cvv_q;
	logic [VIDX_W-1:0] cvi_q;
	logic [CV_W-1:0]   cvl_q;

	logic              res_valid_q;
	logic [STAT_W-1:0] res_status_q;
	logic [MASK_W-1:0] res_gate_q;
	logic [MASK_W-1:0] res_trig_q;
	logic              res_cvv_q;
	logic [VOUT_W-1:0] res_cvi_q;
	logic [CV_W-1:0]   res_cvl_q;
	logic [HOUT_W-1:0] res_held_q;

	vc_op_t            vc_op;
	logic [KEY_W-1:0]  vkey;
	hc_cmd_t           hc_cmd;
	vc_flags_t         vflags [NUM_VOICES];
	logic [KEY_W-1:0]  hkey [HELD_DEPTH];

	logic [NUM_VOICES-1:0] active_v, key_eq_v, gated_eq_v, gate_v, trig_v;
	logic [NUM_VOICES-1:0] steal_v, dup_v, free_v;
	logic [MASK_W-1:0]     gate_m, trig_m;

	logic [KEY_W-1:0]  head;
	logic              step_lt, last_step;
	logic              steal_now, off_hit, rev_now, sounding;
	logic [HCNT_W-1:0] cnt_dec;
	logic              rev_go;
	logic              accept, res_load;
	logic [KEY_W-1:0]  pdiff;
	logic [15:0]       pprod;
	logic [13:0]       pshift;
	logic [CV_W-1:0]   pitch;
	logic [VIDX_W+VOUT_W-1:0] cvi_ext;
	logic [HCNT_W+HOUT_W-1:0] cnt_ext;

	function automatic logic [VIDX_W-1:0] lowest(input logic [NUM_VOICES-1:0] v);
		logic [VIDX_W-1:0] r;
		r = '0;
		for (int i = NUM_VOICES - 1; i >= 0; i--) begin
			if (v[i]) r = VIDX_W'(i);
		end
		return r;
	endfunction

	genvar gi;
	generate
		for (gi = 0; gi < NUM_VOICES; gi++) begin : g_voice
			pva_voice_cell u_voice (
				.clk    (clk),
				.arst_n (arst_n),
				.op     (vc_op),
				.sel    (target_q == VIDX_W'(gi)),
				.vkey   (vkey),
				.ticks  (tt_q),
				.flags  (vflags[gi])
			);
			assign active_v[gi]   = (VCFG_W'(gi) < vc_q);
			assign key_eq_v[gi]   = vflags[gi].key_eq;
			assign gated_eq_v[gi] = vflags[gi].gated_eq;
			assign gate_v[gi]     = vflags[gi].gate;
			assign trig_v[gi]     = vflags[gi].trig;
		end
		for (gi = 0; gi < HELD_DEPTH; gi++) begin : g_held
			pva_held_cell u_held (
				.clk     (clk),
				.idx     (HIDX_W'(gi)),
				.cmd     (hc_cmd),
				.nxt_key (hkey[(gi + 1) % HELD_DEPTH]),
				.key_q   (hkey[gi])
			);
		end
		for (gi = 0; gi < MASK_W; gi++) begin : g_mask
			if (gi < NUM_VOICES) begin : g_on
				assign gate_m[gi] = gate_v[gi];
				assign trig_m[gi] = trig_v[gi];
			end else begin : g_off
				assign gate_m[gi] = 1'b0;
				assign trig_m[gi] = 1'b0;
			end
		end
	endgenerate

	assign steal_v   = key_eq_v & active_v;
	assign dup_v     = gated_eq_v & active_v;
	assign free_v    = ~gate_v & active_v;
	assign sounding  = |gated_eq_v;
	assign head      = hkey[0];
	assign step_lt   = (HCNT_W'(step_q) < cnt_q);
	assign last_step = (step_q == HIDX_W'(HELD_DEPTH - 1));
	assign steal_now = step_lt && !found_q && (|steal_v);
	assign off_hit   = step_lt && !found_q && (head == key_q);
	assign rev_now   = step_lt && !sounding;
	assign cnt_dec   = cnt_q - 1'b1;
	assign rev_go    = ({VCFG_W'(0), cnt_dec} >= {HCNT_W'(0), vc_q}) ||
	                   ({VCFG_W'(0), cnt_dec} >= (HCNT_W + VCFG_W)'(NUM_VOICES));

	assign accept    = in_valid && in_ready;
	assign res_load  = (state_q == S_DONE) && (!res_valid_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);

	assign pdiff  = key_q - PITCH_BASE;
	assign pprod  = 16'(pdiff) * PITCH_MUL;
	assign pshift = pprod[15:2];
	assign pitch  = (key_q <= PITCH_BASE) ? '0 :
	                (pshift > CV_MAX) ? CV_MAX[CV_W-1:0] : pshift[CV_W-1:0];

	assign cvi_ext = {VOUT_W'(0), cvi_q};
	assign cnt_ext = {HOUT_W'(0), cnt_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (req_q)
					REQ_NOTE_ON:  state_d = S_VON_CHECK;
					REQ_NOTE_OFF: state_d = S_OFF_WALK;
					default:      state_d = S_DONE;
				endcase
			end
			S_VON_CHECK: begin
				if (|dup_v) state_d = S_DONE;
				else if (|free_v) state_d = S_LOAD;
				else state_d = S_STEAL_WALK;
			end
			S_STEAL_WALK: begin
				if (last_step) state_d = (found_q || steal_now) ? S_STEAL_OFF : S_DONE;
			end
			S_STEAL_OFF: state_d = S_LOAD;
			S_LOAD:      state_d = S_DONE;
			S_OFF_WALK: begin
				if (last_step) state_d = (found_q || off_hit) ? S_OFF_DEL : S_DONE;
			end
			S_OFF_DEL: begin
				state_d = rev_go ? S_REV_WALK : S_DONE;
			end
			S_REV_WALK: begin
				if (last_step) state_d = (found_q || rev_now) ? S_VON_CHECK : S_DONE;
			end
			S_DONE: begin
				if (res_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		vc_op       = VC_HOLD;
		vkey        = key_q;
		hc_cmd.op   = HC_HOLD;
		hc_cmd.pos  = '0;
		hc_cmd.wkey = key_q;
		case (state_q)
			S_DECODE: begin
				if (req_q == REQ_TICK) vc_op = VC_TICK;
			end
			S_STEAL_WALK, S_REV_WALK: begin
				vkey      = head;
				hc_cmd.op = HC_SHIFT;
			end
			S_STEAL_OFF: begin
				vkey  = fkey_q;
				vc_op = VC_GATE_OFF;
			end
			S_LOAD: begin
				vc_op = VC_LOAD;
				if (!revoice_q && cnt_q < HCNT_W'(HELD_DEPTH)) begin
					hc_cmd.op  = HC_WRITE;
					hc_cmd.pos = cnt_q[HIDX_W-1:0];
				end
			end
			S_OFF_WALK: begin
				hc_cmd.op = HC_SHIFT;
				if (step_q == '0) vc_op = VC_GATE_OFF;
			end
			S_OFF_DEL: begin
				hc_cmd.op  = HC_SHIFT;
				hc_cmd.pos = pos_q;
			end
			default: begin
				vc_op = VC_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vc_q      <= VOICE_COUNT_RST;
			tt_q      <= TRIGGER_TICKS_RST;
			cnt_q     <= '0;
			req_q     <= REQ_TICK;
			key_q     <= '0;
			step_q    <= '0;
			found_q   <= 1'b0;
			fkey_q    <= '0;
			target_q  <= '0;
			pos_q     <= '0;
			revoice_q <= 1'b0;
			status_q  <= ST_DONE;
			cvv_q     <= 1'b0;
			cvi_q     <= '0;
			cvl_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				case (cfg_addr)
					REG_VOICE_COUNT:   vc_q <= cfg_wdata[VCFG_W-1:0];
					REG_TRIGGER_TICKS: tt_q <= cfg_wdata[TICK_W-1:0];
					default:           vc_q <= vc_q;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q     <= req_type;
						key_q     <= key;
						step_q    <= '0;
						found_q   <= 1'b0;
						revoice_q <= 1'b0;
						status_q  <= ST_DONE;
						cvv_q     <= 1'b0;
						cvi_q     <= '0;
						cvl_q     <= '0;
					end
				end
				S_DECODE: begin
					if (req_q == REQ_TICK) status_q <= ST_TICK;
				end
				S_VON_CHECK: begin
					step_q  <= '0;
					found_q <= 1'b0;
					if (|dup_v) begin
						if (!revoice_q) status_q <= ST_DUP;
					end else if (|free_v) begin
						target_q <= lowest(free_v);
					end
				end
				S_STEAL_WALK: begin
					step_q <= step_q + 1'b1;
					if (steal_now) begin
						found_q  <= 1'b1;
						fkey_q   <= head;
						target_q <= lowest(steal_v);
					end
					if (last_step && !found_q && !steal_now && !revoice_q)
						status_q <= ST_NO_VOICE;
				end
				S_LOAD: begin
					cvv_q <= 1'b1;
					cvi_q <= target_q;
					cvl_q <= pitch;
					if (!revoice_q) begin
						if (cnt_q >= HCNT_W'(HELD_DEPTH)) status_q <= ST_FULL;
						else cnt_q <= cnt_q + 1'b1;
					end
				end
				S_OFF_WALK: begin
					step_q <= step_q + 1'b1;
					if (off_hit) begin
						found_q <= 1'b1;
						pos_q   <= step_q;
					end
					if (last_step && !found_q && !off_hit) status_q <= ST_NOT_HELD;
				end
				S_OFF_DEL: begin
					cnt_q   <= cnt_dec;
					step_q  <= '0;
					found_q <= 1'b0;
				end
				S_REV_WALK: begin
					step_q <= step_q + 1'b1;
					if (rev_now) begin
						found_q <= 1'b1;
						fkey_q  <= head;
					end
					if (last_step) begin
						key_q     <= rev_now ? head : fkey_q;
						revoice_q <= 1'b1;
					end
				end
				default: begin
					step_q <= step_q;
				end
			endcase
			if (res_load) res_valid_q <= 1'b1;
			else if (out_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= status_q;
			res_gate_q   <= gate_m;
			res_trig_q   <= trig_m;
			res_cvv_q    <= cvv_q;
			res_cvi_q    <= cvi_ext[VOUT_W-1:0];
			res_cvl_q    <= cvl_q;
			res_held_q   <= cnt_ext[HOUT_W-1:0];
		end
	end

	assign out_valid    = res_valid_q;
	assign status       = res_status_q;
	assign gate_mask    = res_gate_q;
	assign trigger_mask = res_trig_q;
	assign cv_valid     = res_cvv_q;
	assign cv_voice     = res_cvi_q;
	assign cv_value     = res_cvl_q;
	assign held_total   = res_held_q;

endmodule

[src/pva_checker.sv]
// Port-level checks of the voice allocator, bound to the top level.
// Depends on pva_pkg and poly_voice_allocator.
module pva_checker import pva_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_wen,
	input logic              cfg_addr,
	input logic [CFG_W-1:0]  cfg_wdata,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        req_type,
	input logic [KEY_W-1:0]  key,
	input logic              out_valid,
	input logic              out_ready,
	input logic [STAT_W-1:0] status,
	input logic [MASK_W-1:0] gate_mask,
	input logic [MASK_W-1:0] trigger_mask,
	input logic              cv_valid,
	input logic [VOUT_W-1:0] cv_voice,
	input logic [CV_W-1:0]   cv_value,
	input logic [HOUT_W-1:0] held_total
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(gate_mask) &&
		$stable(cv_value) && $stable(held_total))
		else $error("result changed while stalled");

	a_cv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cv_valid |-> cv_voice == '0 && cv_value == '0)
		else $error("pitch fields set without a pitch write");

	a_no_cv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_TICK || status == ST_DUP || status == ST_NO_VOICE ||
		status == ST_NOT_HELD) |-> !cv_valid)
		else $error("pitch write on a result that voices nothing");

	a_voiced_gate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cv_valid && ({5'b0, cv_voice} < MASK_W) |->
		gate_mask[cv_voice] && trigger_mask[cv_voice])
		else $error("voiced channel has no gate or trigger");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> held_total <= HOUT_W'(HELD_DEPTH))
		else $error("held count beyond list depth");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (.*);

[test/tb_poly_voice_allocator.sv]
`timescale 1ns / 1ps
// Testbench of poly_voice_allocator: random and directed note events through a valid/ready
// driver, each result checked against a cycle-free allocation predictor. Depends on pva_pkg and poly_voice_allocator.
module tb_poly_voice_allocator;
	import pva_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_TAIL  = 3 * HELD_DEPTH + 8;

	typedef struct packed {
		logic [1:0]       req;
		logic [KEY_W-1:0] note;
	} midi_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [MASK_W-1:0] gate;
		logic [MASK_W-1:0] trig;
		logic              cv_valid;
		logic [VOUT_W-1:0] cv_voice;
		logic [CV_W-1:0]   cv_value;
		logic [HOUT_W-1:0] held;
	} alloc_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic              cfg_addr = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        req_type = REQ_TICK;
	logic [KEY_W-1:0]  key = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic [MASK_W-1:0] gate_mask;
	logic [MASK_W-1:0] trigger_mask;
	logic              cv_valid;
	logic [VOUT_W-1:0] cv_voice;
	logic [CV_W-1:0]   cv_value;
	logic [HOUT_W-1:0] held_total;

	poly_voice_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .key(key),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.gate_mask(gate_mask), .trigger_mask(trigger_mask), .cv_valid(cv_valid),
		.cv_voice(cv_voice), .cv_value(cv_value), .held_total(held_total)
	);

	midi_req_t     midi_req_q[$];
	alloc_result_t alloc_results_q[$];
	midi_req_t     next_req;
	alloc_result_t want;
	int            struck_keys[$];
	int items_pushed = 0;
	int results_seen = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	// allocator shadow state
	logic [KEY_W-1:0]  v_key  [NUM_VOICES];
	bit                v_gate [NUM_VOICES];
	bit                v_trig [NUM_VOICES];
	logic [TICK_W-1:0] v_left [NUM_VOICES];
	logic [KEY_W-1:0]  held_q [HELD_DEPTH];
	int held_n;
	int cfg_voices;
	int cfg_ticks;
	bit cv_hit;
	int cv_at;
	int cv_lvl;

	function automatic int active_n();
		return (cfg_voices > NUM_VOICES) ? NUM_VOICES : cfg_voices;
	endfunction

	function automatic int key_pitch(int k);
		int v;
		if (k <= int'(PITCH_BASE))
			return 0;
		v = ((k - int'(PITCH_BASE)) * int'(PITCH_MUL)) >>> 2;
		return (v > int'(CV_MAX)) ? int'(CV_MAX) : v;
	endfunction

	function automatic void silence(int k);
		for (int i = 0; i < NUM_VOICES; i++)
			if (v_gate[i] && v_key[i] == k)
				v_gate[i] = 1'b0;
	endfunction

	function automatic logic [STAT_W-1:0] assign_voice(int k);
		int n;
		int target;
		bit found;
		n = active_n();
		target = NUM_VOICES;
		found = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (v_gate[i] && v_key[i] == k)
				return ST_DUP;
			if (!v_gate[i] && target == NUM_VOICES)
				target = i;
		end
		if (target == NUM_VOICES) begin
			// steal from the oldest held key that owns an active voice
			for (int i = 0; i < held_n && !found; i++)
				for (int j = 0; j < n && !found; j++)
					if (v_key[j] == held_q[i]) begin
						silence(held_q[i]);
						target = j;
						found = 1'b1;
					end
			if (!found)
				return ST_NO_VOICE;
		end
		v_key[target]  = KEY_W'(k);
		v_gate[target] = 1'b1;
		v_trig[target] = 1'b1;
		v_left[target] = TICK_W'(cfg_ticks);
		cv_hit = 1'b1;
		cv_at  = target;
		cv_lvl = key_pitch(k);
		return ST_DONE;
	endfunction

	function automatic logic [STAT_W-1:0] release_key(int k);
		int pos;
		bit sounding;
		bit done;
		silence(k);
		pos = held_n;
		done = 1'b0;
		for (int i = 0; i < held_n; i++)
			if (pos == held_n && held_q[i] == k)
				pos = i;
		if (pos == held_n)
			return ST_NOT_HELD;
		for (int i = pos; i + 1 < held_n; i++)
			held_q[i] = held_q[i + 1];
		held_n--;
		if (held_n >= active_n()) begin
			// revoice the newest held key that has lost its voice
			for (int i = held_n; i > 0 && !done; i--) begin
				sounding = 1'b0;
				for (int j = 0; j < NUM_VOICES; j++)
					if (v_gate[j] && v_key[j] == held_q[i - 1])
						sounding = 1'b1;
				if (!sounding) begin
					void'(assign_voice(held_q[i - 1]));
					done = 1'b1;
				end
			end
		end
		return ST_DONE;
	endfunction

	function automatic void count_down();
		for (int i = 0; i < NUM_VOICES; i++)
			if (v_trig[i]) begin
				if (v_left[i] > 0)
					v_left[i]--;
				if (v_left[i] == 0)
					v_trig[i] = 1'b0;
			end
	endfunction

	function automatic alloc_result_t allocate_step(logic [1:0] rq, logic [KEY_W-1:0] k);
		alloc_result_t r;
		logic [STAT_W-1:0] st;
		r = '0;
		cv_hit = 1'b0;
		cv_at = 0;
		cv_lvl = 0;
		st = ST_DONE;
		case (rq)
			REQ_TICK: begin
				count_down();
				st = ST_TICK;
			end
			REQ_NOTE_ON: begin
				st = assign_voice(k);
				if (st == ST_DONE) begin
					if (held_n >= HELD_DEPTH) begin
						st = ST_FULL;
					end else begin
						held_q[held_n] = k;
						held_n++;
					end
				end
			end
			REQ_NOTE_OFF: st = release_key(k);
			default: ;
		endcase
		r.status = st;
		for (int i = 0; i < NUM_VOICES && i < MASK_W; i++) begin
			r.gate[i] = v_gate[i];
			r.trig[i] = v_trig[i];
		end
		r.cv_valid = cv_hit;
		r.cv_voice = cv_hit ? VOUT_W'(cv_at) : '0;
		r.cv_value = cv_hit ? CV_W'(cv_lvl) : '0;
		r.held = HOUT_W'(held_n);
		return r;
	endfunction

	task automatic flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic check_field(string name, int exp_v, int got_v);
		if (exp_v != got_v)
			flag_error($sformatf("%s expected %0d actual %0d", name, exp_v, got_v));
	endtask

	task automatic push_item(logic [1:0] rq, int k);
		midi_req_q.push_back('{req: rq, note: KEY_W'(k)});
		items_pushed++;
	endtask

	task automatic drain();
		while (results_seen < items_pushed)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic program_regs(int voices, int ticks);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_addr  <= REG_VOICE_COUNT;
		cfg_wdata <= CFG_W'(voices & 15) | (CFG_W'($urandom_range(15)) << VCFG_W);
		cfg_voices = voices & 15;
		@(posedge clk);
		cfg_addr  <= REG_TRIGGER_TICKS;
		cfg_wdata <= CFG_W'(ticks);
		cfg_ticks = ticks & 255;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic gen_chunk(int count, int on_pct);
		int r;
		int k;
		int idx;
		int made;
		int base;
		made = 0;
		base = $urandom_range(100, 20);
		while (made < count) begin
			r = $urandom_range(99);
			if (r < 12) begin
				k = $urandom_range(3);
				push_item(k[1:0], $urandom_range(127));
				if (k != REQ_UNUSED)
					made++;
			end else if (r < 12 + on_pct) begin
				if ($urandom_range(4) == 0)
					k = $urandom_range(127);
				else
					k = (base + $urandom_range(15)) % 128;
				push_item(REQ_NOTE_ON, k);
				struck_keys.push_back(k);
				if (struck_keys.size() > 40)
					void'(struck_keys.pop_front());
				made++;
			end else if (r < 88) begin
				if (struck_keys.size() > 0 && $urandom_range(7) != 0) begin
					idx = $urandom_range(struck_keys.size() - 1);
					push_item(REQ_NOTE_OFF, struck_keys[idx]);
					struck_keys.delete(idx);
				end else begin
					push_item(REQ_NOTE_OFF, $urandom_range(127));
				end
				made++;
			end else begin
				push_item(REQ_TICK, $urandom_range(127));
				made++;
			end
		end
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// driver: hold the payload until transfer, then advance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				alloc_results_q.push_back(allocate_step(req_type, key));
			if (midi_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = midi_req_q.pop_front();
				in_valid <= 1'b1;
				req_type <= next_req.req;
				key      <= next_req.note;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (alloc_results_q.size() == 0) begin
					flag_error("result with no expectation waiting");
				end else begin
					want = alloc_results_q.pop_front();
					check_field("status", want.status, status);
					check_field("gate_mask", want.gate, gate_mask);
					check_field("trigger_mask", want.trig, trigger_mask);
					check_field("cv_valid", want.cv_valid, cv_valid);
					check_field("cv_voice", want.cv_voice, cv_voice);
					check_field("cv_value", want.cv_value, cv_value);
					check_field("held_total", want.held, held_total);
				end
				results_seen++;
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int vc_tab[8];
		int tt_tab[8];
		vc_tab = '{0, 15, 1, 8, 3, 9, 8, 5};
		tt_tab = '{1, 255, 0, 1, 2, 7, 255, 3};
		for (int i = 0; i < NUM_VOICES; i++) begin
			v_key[i]  = '0;
			v_gate[i] = 1'b0;
			v_trig[i] = 1'b0;
			v_left[i] = '0;
		end
		for (int i = 0; i < HELD_DEPTH; i++)
			held_q[i] = '0;
		held_n = 0;
		cfg_voices = int'(VOICE_COUNT_RST);
		cfg_ticks  = int'(TRIGGER_TICKS_RST);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_item(REQ_TICK, 0);
		push_item(REQ_NOTE_ON, 0);
		push_item(REQ_NOTE_ON, 127);
		push_item(REQ_NOTE_ON, 53);
		push_item(REQ_NOTE_ON, 54);
		push_item(REQ_NOTE_ON, 68);
		push_item(REQ_NOTE_ON, 67);
		push_item(REQ_NOTE_ON, 127);
		push_item(REQ_NOTE_OFF, 99);
		push_item(REQ_TICK, 0);
		push_item(REQ_TICK, 0);
		push_item(REQ_UNUSED, 127);
		push_item(REQ_NOTE_ON, 70);
		push_item(REQ_NOTE_ON, 71);
		push_item(REQ_NOTE_ON, 72);
		push_item(REQ_NOTE_OFF, 127);
		push_item(REQ_TICK, 127);
		// fill the held list by stealing, then overflow it
		for (int k = 80; k <= 88; k++)
			push_item(REQ_NOTE_ON, k);
		drain();

		for (int p = 0; p < 8; p++) begin
			program_regs(vc_tab[p], tt_tab[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 63; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 63; end
				default: begin send_idle_pct = 38; stall_pct = 38; end
			endcase
			gen_chunk(30, (p % 2 == 0) ? 45 : 66);
			drain();
			gen_chunk(30, (p % 2 == 0) ? 66 : 45);
			drain();
		end

		if (mismatches == 0 && alloc_results_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
